@@ hdl/plr_pkg.sv @@
// plr_pkg: shared types, constants and register map of the plateau learning-rate reducer.
// No dependencies.
package plr_pkg;

    localparam int GROUPS   = 4;
    localparam int RATE_W   = 32;
    localparam int METRIC_W = 32;
    localparam int MARGIN_W = 31;
    localparam int FACTOR_W = 16;
    localparam int COUNT_W  = 16;
    localparam int BAD_W    = 17;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [BAD_W-1:0] BAD_MAX = {BAD_W{1'b1}};

    localparam logic [FACTOR_W-1:0] FACTOR_RST   = 16'd32768;
    localparam logic [COUNT_W-1:0]  PATIENCE_RST = 16'd10;

    typedef enum logic [2:0] {
        REG_MAXIMIZE   = 3'd0,
        REG_MARGIN     = 3'd1,
        REG_FACTOR     = 3'd2,
        REG_PATIENCE   = 3'd3,
        REG_COOLDOWN   = 3'd4,
        REG_FLOOR      = 3'd5,
        REG_MIN_CHANGE = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic                maximize;
        logic [MARGIN_W-1:0] margin;
        logic [FACTOR_W-1:0] factor;
        logic [COUNT_W-1:0]  patience;
        logic [COUNT_W-1:0]  cooldown;
        logic [RATE_W-1:0]   floor_rate;
        logic [RATE_W-1:0]   min_change;
    } t_cfg;

endpackage

@@ hdl/plateau_lr_reducer.sv @@
// plateau_lr_reducer: top level, APB register file, input/result registers.
// Depends on plr_pkg, plr_ctrl, plr_lane.
//
// Reduce-on-plateau learning-rate controller.
// Input channel (i_in_valid / o_in_ready): one transfer per epoch, carrying
// the monitored metric (signed Q16.16) and the current rate of each group
// (Q8.24). Result channel (o_out_valid / i_out_ready): one transfer per
// epoch with the new rates and a flag that is set when any rate was lowered.
// An epoch is taken into the input register, then moves on to the result
// register once that register is empty or being read out.
// Throughput: one epoch per cycle while the receiver takes results; the
// compare, counter update and per-group multiply-clamp all sit between the
// two registers. When the receiver stalls, the result register holds and the
// input register still takes one more epoch; beyond that o_in_ready drops.
// Configuration goes through the APB port, register i at byte address 4*i;
// write it only while no epoch is in flight. Reset (synchronous, active low)
// restores register defaults, forgets the best metric, clears the bad-epoch
// and cooldown counters and empties both pipeline registers.
module plateau_lr_reducer import plr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [METRIC_W-1:0] i_metric,
    input  logic [RATE_W-1:0]          i_rate_in_0,
    input  logic [RATE_W-1:0]          i_rate_in_1,
    input  logic [RATE_W-1:0]          i_rate_in_2,
    input  logic [RATE_W-1:0]          i_rate_in_3,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [RATE_W-1:0]          o_rate_out_0,
    output logic [RATE_W-1:0]          o_rate_out_1,
    output logic [RATE_W-1:0]          o_rate_out_2,
    output logic [RATE_W-1:0]          o_rate_out_3,
    output logic                       o_reduced,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    t_cfg                       r_cfg;
    logic                       w_cfg_wr;
    t_reg_idx                   w_idx;

    logic                       r_in_vld;
    logic signed [METRIC_W-1:0] r_metric;
    logic [RATE_W-1:0]          r_rate [GROUPS];
    logic                       r_out_vld;
    logic [RATE_W-1:0]          r_rate_out [GROUPS];
    logic                       r_reduced;

    logic [RATE_W-1:0]          w_rate_in [GROUPS];
    logic [RATE_W-1:0]          w_rate_new [GROUPS];
    logic [GROUPS-1:0]          w_lowered;
    logic                       w_advance;
    logic                       w_fire;
    logic                       w_reduce;

    // ---------------- register file ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.maximize   <= 1'b0;
            r_cfg.margin     <= '0;
            r_cfg.factor     <= FACTOR_RST;
            r_cfg.patience   <= PATIENCE_RST;
            r_cfg.cooldown   <= '0;
            r_cfg.floor_rate <= '0;
            r_cfg.min_change <= '0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_MAXIMIZE:   r_cfg.maximize   <= pwdata[0];
                REG_MARGIN:     r_cfg.margin     <= pwdata[MARGIN_W-1:0];
                REG_FACTOR:     r_cfg.factor     <= pwdata[FACTOR_W-1:0];
                REG_PATIENCE:   r_cfg.patience   <= pwdata[COUNT_W-1:0];
                REG_COOLDOWN:   r_cfg.cooldown   <= pwdata[COUNT_W-1:0];
                REG_FLOOR:      r_cfg.floor_rate <= pwdata[RATE_W-1:0];
                REG_MIN_CHANGE: r_cfg.min_change <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAXIMIZE:   prdata = {{(DATA_W-1){1'b0}}, r_cfg.maximize};
            REG_MARGIN:     prdata = {{(DATA_W-MARGIN_W){1'b0}}, r_cfg.margin};
            REG_FACTOR:     prdata = {{(DATA_W-FACTOR_W){1'b0}}, r_cfg.factor};
            REG_PATIENCE:   prdata = {{(DATA_W-COUNT_W){1'b0}}, r_cfg.patience};
            REG_COOLDOWN:   prdata = {{(DATA_W-COUNT_W){1'b0}}, r_cfg.cooldown};
            REG_FLOOR:      prdata = r_cfg.floor_rate;
            REG_MIN_CHANGE: prdata = r_cfg.min_change;
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    assign w_rate_in[0] = i_rate_in_0;
    assign w_rate_in[1] = i_rate_in_1;
    assign w_rate_in[2] = i_rate_in_2;
    assign w_rate_in[3] = i_rate_in_3;

    assign w_advance  = !r_out_vld || i_out_ready;
    assign w_fire     = r_in_vld && w_advance;
    assign o_in_ready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_metric <= i_metric;
            r_rate   <= w_rate_in;
        end
        if (w_fire) begin
            r_rate_out <= w_rate_new;
            r_reduced  <= |w_lowered;
        end
    end

    plr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_metric (r_metric),
        .i_cfg    (r_cfg),
        .o_reduce (w_reduce)
    );

    for (genvar g = 0; g < GROUPS; g++) begin : g_lane
        plr_lane u_lane (
            .i_rate       (r_rate[g]),
            .i_factor     (r_cfg.factor),
            .i_floor      (r_cfg.floor_rate),
            .i_min_change (r_cfg.min_change),
            .i_reduce     (w_reduce),
            .o_rate       (w_rate_new[g]),
            .o_lowered    (w_lowered[g])
        );
    end

    assign o_out_valid  = r_out_vld;
    assign o_rate_out_0 = r_rate_out[0];
    assign o_rate_out_1 = r_rate_out[1];
    assign o_rate_out_2 = r_rate_out[2];
    assign o_rate_out_3 = r_rate_out[3];
    assign o_reduced    = r_reduced;

endmodule

@@ hdl/plr_ctrl.sv @@
// plr_ctrl: best-metric tracking, bad-epoch and cooldown counters, reduce decision.
// Depends on plr_pkg.
module plr_ctrl import plr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic signed [METRIC_W-1:0] i_metric,
    input  t_cfg                       i_cfg,
    output logic                       o_reduce
);

    logic signed [METRIC_W-1:0] r_best;
    logic                       r_best_vld;
    logic [BAD_W-1:0]           r_bad;
    logic [COUNT_W-1:0]         r_cool;

    logic [BAD_W-1:0]           n_bad;
    logic [COUNT_W-1:0]         n_cool;

    logic signed [METRIC_W+1:0] w_best_x;
    logic signed [METRIC_W+1:0] w_metric_x;
    logic signed [METRIC_W+1:0] w_margin_x;
    logic                       w_better;
    logic [BAD_W-1:0]           w_bad_step;

    // 34-bit compare: best +/- margin can never wrap
    assign w_best_x   = {{2{r_best[METRIC_W-1]}}, r_best};
    assign w_metric_x = {{2{i_metric[METRIC_W-1]}}, i_metric};
    assign w_margin_x = {3'b000, i_cfg.margin};

    always_comb begin
        if (!r_best_vld) begin
            w_better = 1'b1;
        end else if (i_cfg.maximize) begin
            w_better = w_metric_x > (w_best_x + w_margin_x);
        end else begin
            w_better = w_metric_x < (w_best_x - w_margin_x);
        end

        if (w_better) begin
            w_bad_step = '0;
        end else if (r_bad != BAD_MAX) begin
            w_bad_step = r_bad + BAD_W'(1);
        end else begin
            w_bad_step = r_bad;
        end

        n_cool = r_cool;
        n_bad  = w_bad_step;
        if (r_cool != '0) begin
            n_cool = r_cool - COUNT_W'(1);
            n_bad  = '0;
        end

        o_reduce = n_bad > {1'b0, i_cfg.patience};
        if (o_reduce) begin
            n_cool = i_cfg.cooldown;
            n_bad  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
            r_bad      <= '0;
            r_cool     <= '0;
        end else if (i_fire) begin
            r_best_vld <= r_best_vld | w_better;
            r_bad      <= n_bad;
            r_cool     <= n_cool;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_better) begin
            r_best <= i_metric;
        end
    end

endmodule

@@ hdl/plr_lane.sv @@
// plr_lane: one group's rate scaling, floor clamp and minimum-decrease test.
// Depends on plr_pkg.
module plr_lane import plr_pkg::*; (
    input  logic [RATE_W-1:0]   i_rate,
    input  logic [FACTOR_W-1:0] i_factor,
    input  logic [RATE_W-1:0]   i_floor,
    input  logic [RATE_W-1:0]   i_min_change,
    input  logic                i_reduce,
    output logic [RATE_W-1:0]   o_rate,
    output logic                o_lowered
);

    logic [RATE_W+FACTOR_W-1:0] w_prod;
    logic [RATE_W-1:0]          w_scaled;
    logic [RATE_W-1:0]          w_clamped;
    logic [RATE_W-1:0]          w_drop;
    logic                       w_take;

    assign w_prod    = i_rate * i_factor;
    assign w_scaled  = w_prod[RATE_W+FACTOR_W-1:FACTOR_W];
    assign w_clamped = (w_scaled < i_floor) ? i_floor : w_scaled;
    // drop only meaningful when rate is above the clamped value
    assign w_drop    = i_rate - w_clamped;
    assign w_take    = (i_rate > w_clamped) && (w_drop > i_min_change);

    assign o_lowered = i_reduce && w_take;
    assign o_rate    = o_lowered ? w_clamped : i_rate;

endmodule

@@ hdl/plr_checker.sv @@
// plr_checker: port-level assertions for plateau_lr_reducer, bound to the top level.
// Depends on plr_pkg and plateau_lr_reducer.
module plr_checker import plr_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [RATE_W-1:0]          o_rate_out_0,
    input logic [RATE_W-1:0]          o_rate_out_1,
    input logic [RATE_W-1:0]          o_rate_out_2,
    input logic [RATE_W-1:0]          o_rate_out_3,
    input logic                       o_reduced
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // with the result register empty the input side never blocks
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result register empty");

    // an accepted epoch reaches the result register if the receiver is ready while it waits in the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready |=> o_out_valid)
        else $error("result missing two cycles after transfer");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_rate_out_0) && $stable(o_rate_out_1)
             && $stable(o_rate_out_2) && $stable(o_rate_out_3)
             && $stable(o_reduced)))
        else $error("result changed while stalled");

endmodule

bind plateau_lr_reducer plr_checker u_plr_checker (.*);
